>>> sv/two_link_planar_ik_macros.svh
// Assertion macros used by the checker file.
`ifndef TWO_LINK_PLANAR_IK_MACROS_SVH
`define TWO_LINK_PLANAR_IK_MACROS_SVH

// Check that expr holds at every rising clock edge outside reset.
`define TLIK_ASSERT(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// Check that expr never holds outside reset.
`define TLIK_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> sv/tlik_pkg.sv
package tlik_pkg;
	localparam int POS_W    = 24;
	localparam int LEN_W    = 23;
	localparam int SH_W     = 17;
	localparam int EL_W     = 16;
	localparam int Z_W      = 20;
	localparam int IDX_W    = 2;
	localparam int ATAN_LAT = 30;

	localparam logic [IDX_W-1:0] REG_LINK1 = 2'd0;
	localparam logic [IDX_W-1:0] REG_LINK2 = 2'd1;

	localparam logic [LEN_W-1:0] LEN_RESET = 23'd65536;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic                    neg;
		logic                    unr;
	} pt_t;
endpackage

>>> sv/two_link_planar_ik.sv
// Channel   Handshake              Payload
// --------  ---------------------  ---------------------------------------------
// target    start / busy           target_x, target_y
// result    done (strobe only)     shoulder_angle, elbow_angle, reachable, last
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A new point is refused while busy: busy is raised in the cycle after each
// transfer and drops again, since a point gives up to two results on one output.
// The second result, when there is one, follows the first in the next cycle.
// Reset clears the valid bits and busy and sets the link lengths to 1.0 m each.
// The receiver cannot stall; the pipeline never holds.
module two_link_planar_ik (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [tlik_pkg::POS_W-1:0]   target_x,
	input  logic signed [tlik_pkg::POS_W-1:0]   target_y,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic        [tlik_pkg::IDX_W-1:0]   cfg_index,
	input  logic        [tlik_pkg::LEN_W-1:0]   cfg_data,
	output logic                                done,
	output logic signed [tlik_pkg::SH_W-1:0]    shoulder_angle,
	output logic signed [tlik_pkg::EL_W-1:0]    elbow_angle,
	output logic                                reachable,
	output logic                                last
);
	import tlik_pkg::*;

	localparam int DW    = 47;  // 2 L1 L2
	localparam int PW    = 48;  // divider remainder, |num|
	localparam int QW    = 31;  // cosine magnitude, Q1.30
	localparam int RW    = 62;  // square root working width
	localparam int MW    = 56;  // second atan2 operands
	localparam int DIV_N = 31;
	localparam int SQ_N  = 31;
	localparam logic signed [17:0] SHOULDER_MAX = 18'sd51472;
	localparam logic signed [17:0] ELBOW_MAX    = 18'sd25736;

	typedef struct packed {
		pt_t           pt;
		logic [DW-1:0] den;
		logic [PW-1:0] rem;
		logic [QW-1:0] quo;
	} dv_t;

	typedef struct packed {
		pt_t                pt;
		logic signed [31:0] cq;
		logic [RW-1:0]      rem;
		logic [RW-1:0]      res;
	} sq_t;

	// Round a Q.16 angle to Q3.13 (add half, floor) and saturate.
	function automatic logic signed [17:0] rnd_sat(input logic signed [20:0] v,
			input logic signed [17:0] lim);
		logic signed [21:0] t;
		t = (22'(v) + 22'sd4) >>> 3;
		if (t > 22'(lim))
			rnd_sat = lim;
		else if (t < -22'(lim))
			rnd_sat = -lim;
		else
			rnd_sat = 18'(t);
	endfunction

	// ---------------------------------------------------------------------
	// Configuration: always ready, unknown indexes are dropped.
	// ---------------------------------------------------------------------
	logic [LEN_W-1:0] link1_q, link2_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link1_q <= LEN_RESET;
			link2_q <= LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINK1: link1_q <= cfg_data;
				REG_LINK2: link2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Input transfer; hold busy for one cycle after each point.
	// ---------------------------------------------------------------------
	logic accept, busy_q;
	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else
			busy_q <= accept;
	end

	// ---------------------------------------------------------------------
	// Front end: squares, numerator, reach test, clamp.
	// ---------------------------------------------------------------------
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	pt_t                  pt_s1, pt_s2, pt_s3, pt_s4, pt_s5;
	logic [PW-1:0]        xx_s2, yy_s2, sxy_s3, mag_s5;
	logic [45:0]          l1sq_s2, l2sq_s2;
	logic [DW-1:0]        sl_s3, den_s2, den_s3, den_s4, den_s5;
	logic                 zl_s2, zl_s3, zl_s4, zl_s5;
	logic signed [48:0]   num_s4;
	logic signed [PW-1:0] xe, ye;
	logic [45:0]          l1e, l2e;
	logic                 ovr;
	logic [PW-1:0]        diff;

	always_comb begin
		xe   = PW'(pt_s1.x);
		ye   = PW'(pt_s1.y);
		l1e  = 46'(link1_q);
		l2e  = 46'(link2_q);
		ovr  = mag_s5 > PW'(den_s5);
		diff = mag_s5 - PW'(den_s5);
	end

	logic [DIV_N:0] dvv_s;
	dv_t            dv_s [0:DIV_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			dvv_s[0] <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dvv_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		pt_s1.x   <= target_x;
		pt_s1.y   <= target_y;
		pt_s1.neg <= 1'b0;
		pt_s1.unr <= 1'b0;
		// s2: products
		pt_s2   <= pt_s1;
		xx_s2   <= PW'(xe * xe);
		yy_s2   <= PW'(ye * ye);
		l1sq_s2 <= l1e * l1e;
		l2sq_s2 <= l2e * l2e;
		den_s2  <= {46'(l1e * l2e), 1'b0};
		zl_s2   <= (link1_q == '0) || (link2_q == '0);
		// s3: partial sums
		pt_s3  <= pt_s2;
		sxy_s3 <= xx_s2 + yy_s2;
		sl_s3  <= DW'(l1sq_s2) + DW'(l2sq_s2);
		den_s3 <= den_s2;
		zl_s3  <= zl_s2;
		// s4: numerator
		pt_s4  <= pt_s3;
		num_s4 <= $signed({1'b0, sxy_s3}) - $signed({2'b00, sl_s3});
		den_s4 <= den_s3;
		zl_s4  <= zl_s3;
		// s5: magnitude and sign
		pt_s5  <= '{x: pt_s4.x, y: pt_s4.y, neg: num_s4[48], unr: pt_s4.unr};
		mag_s5 <= num_s4[48] ? PW'(-num_s4) : PW'(num_s4);
		den_s5 <= den_s4;
		zl_s5  <= zl_s4;
		// s6: out-of-reach test beyond one Q1.30 LSB, clamp to den
		dv_s[0].pt  <= '{x: pt_s5.x, y: pt_s5.y, neg: pt_s5.neg,
			unr: zl_s5 || (ovr && (diff > PW'(den_s5 >> 30)))};
		dv_s[0].den <= den_s5;
		dv_s[0].rem <= ovr ? PW'(den_s5) : mag_s5;
		dv_s[0].quo <= '0;
	end

	// ---------------------------------------------------------------------
	// Restoring divider, one quotient bit per stage.
	// ---------------------------------------------------------------------
	for (genvar k = 1; k <= DIV_N; k++) begin : g_div
		logic [PW-1:0] r;
		logic          ge;
		always_comb begin
			r  = (k == 1) ? dv_s[k-1].rem : (dv_s[k-1].rem << 1);
			ge = r >= PW'(dv_s[k-1].den);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvv_s[k] <= 1'b0;
			else
				dvv_s[k] <= dvv_s[k-1];
		end
		always_ff @(posedge clk) begin
			dv_s[k].pt  <= dv_s[k-1].pt;
			dv_s[k].den <= dv_s[k-1].den;
			dv_s[k].rem <= ge ? (r - PW'(dv_s[k-1].den)) : r;
			dv_s[k].quo <= {dv_s[k-1].quo[QW-2:0], ge};
		end
	end

	// ---------------------------------------------------------------------
	// Signed cosine, then 1 - c^2 for the square root.
	// ---------------------------------------------------------------------
	logic               v_c1;
	pt_t                pt_c1;
	logic signed [31:0] cq_c1;
	logic [RW-1:0]      qsq_c1;
	logic [RW-1:0]      qe;
	logic [SQ_N:0]      sqv_s;
	sq_t                sq_s [0:SQ_N];

	assign qe = RW'(dv_s[DIV_N].quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c1     <= 1'b0;
			sqv_s[0] <= 1'b0;
		end else begin
			v_c1     <= dvv_s[DIV_N];
			sqv_s[0] <= v_c1;
		end
	end

	always_ff @(posedge clk) begin
		pt_c1  <= dv_s[DIV_N].pt;
		cq_c1  <= dv_s[DIV_N].pt.neg ? -$signed({1'b0, dv_s[DIV_N].quo})
		                             : $signed({1'b0, dv_s[DIV_N].quo});
		qsq_c1 <= qe * qe;
		sq_s[0].pt  <= pt_c1;
		sq_s[0].cq  <= cq_c1;
		sq_s[0].rem <= (RW'(1) << 60) - qsq_c1;
		sq_s[0].res <= '0;
	end

	// ---------------------------------------------------------------------
	// Digit-by-digit square root, one result bit per stage.
	// ---------------------------------------------------------------------
	for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
		localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2 * (k - 1));
		logic [RW-1:0] t;
		always_comb begin
			t = sq_s[k-1].res + BIT;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqv_s[k] <= 1'b0;
			else
				sqv_s[k] <= sqv_s[k-1];
		end
		always_ff @(posedge clk) begin
			sq_s[k].pt <= sq_s[k-1].pt;
			sq_s[k].cq <= sq_s[k-1].cq;
			if (sq_s[k-1].rem >= t) begin
				sq_s[k].rem <= sq_s[k-1].rem - t;
				sq_s[k].res <= (sq_s[k-1].res >> 1) + BIT;
			end else begin
				sq_s[k].rem <= sq_s[k-1].rem;
				sq_s[k].res <= sq_s[k-1].res >> 1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Operands of the second atan2: L2 s and L1 + L2 c, kept exact.
	// ---------------------------------------------------------------------
	logic               v_m1, v_m2;
	pt_t                pt_m1, pt_m2;
	logic [QW-1:0]      s_m1;
	logic signed [31:0] cq_m1, cq_m2, es_m2, eds_m2;
	logic [53:0]        ls_m1;
	logic signed [54:0] lc_m1;
	logic signed [MW-1:0] ax_m2, ayu_m2, ayd_m2;
	logic               sz_m2;
	logic [QW-1:0]      s_fin;

	assign s_fin = sq_s[SQ_N].res[QW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
		end else begin
			v_m1 <= sqv_s[SQ_N];
			v_m2 <= v_m1;
		end
	end

	always_ff @(posedge clk) begin
		pt_m1 <= sq_s[SQ_N].pt;
		cq_m1 <= sq_s[SQ_N].cq;
		s_m1  <= s_fin;
		ls_m1 <= 54'(link2_q) * 54'(s_fin);
		lc_m1 <= $signed({32'd0, link2_q}) * 55'(sq_s[SQ_N].cq);
		pt_m2  <= pt_m1;
		cq_m2  <= cq_m1;
		es_m2  <= $signed({1'b0, s_m1});
		eds_m2 <= -$signed({1'b0, s_m1});
		ax_m2  <= $signed(MW'(link1_q) << 30) + MW'(lc_m1);
		ayu_m2 <= $signed(MW'(ls_m1));
		ayd_m2 <= -$signed(MW'(ls_m1));
		sz_m2  <= s_m1 <= QW'(1);
	end

	// ---------------------------------------------------------------------
	// Five CORDIC units run side by side: base angle, both elbows, both
	// shoulder corrections. Track valid and flags alongside them.
	// ---------------------------------------------------------------------
	logic signed [Z_W-1:0] zb, zeu, zed, zsu, zsd;

	tlik_atan2 #(.IW(POS_W)) u_base (.clk(clk), .y(pt_m2.y), .x(pt_m2.x), .z(zb));
	tlik_atan2 #(.IW(32))    u_elu  (.clk(clk), .y(es_m2),   .x(cq_m2),   .z(zeu));
	tlik_atan2 #(.IW(32))    u_eld  (.clk(clk), .y(eds_m2),  .x(cq_m2),   .z(zed));
	tlik_atan2 #(.IW(MW))    u_shu  (.clk(clk), .y(ayu_m2),  .x(ax_m2),   .z(zsu));
	tlik_atan2 #(.IW(MW))    u_shd  (.clk(clk), .y(ayd_m2),  .x(ax_m2),   .z(zsd));

	logic [ATAN_LAT-1:0] av_s, au_s, az_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			av_s <= '0;
		else
			av_s <= {av_s[ATAN_LAT-2:0], v_m2};
	end

	always_ff @(posedge clk) begin
		au_s <= {au_s[ATAN_LAT-2:0], pt_m2.unr};
		az_s <= {az_s[ATAN_LAT-2:0], sz_m2};
	end

	// ---------------------------------------------------------------------
	// Shoulder differences, then rounding and saturation.
	// ---------------------------------------------------------------------
	logic                  v_f1, v_f2, unr_f1, unr_f2, sz_f1, sz_f2;
	logic signed [20:0]    shu_f1, shd_f1, elu_f1, eld_f1;
	logic signed [SH_W-1:0] shu_f2, shd_f2;
	logic signed [EL_W-1:0] elu_f2, eld_f2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else begin
			v_f1 <= av_s[ATAN_LAT-1];
			v_f2 <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		unr_f1 <= au_s[ATAN_LAT-1];
		sz_f1  <= az_s[ATAN_LAT-1];
		shu_f1 <= 21'(zb) - 21'(zsu);
		shd_f1 <= 21'(zb) - 21'(zsd);
		elu_f1 <= 21'(zeu);
		eld_f1 <= 21'(zed);
		unr_f2 <= unr_f1;
		sz_f2  <= sz_f1;
		shu_f2 <= SH_W'(rnd_sat(shu_f1, SHOULDER_MAX));
		shd_f2 <= SH_W'(rnd_sat(shd_f1, SHOULDER_MAX));
		elu_f2 <= EL_W'(rnd_sat(elu_f1, ELBOW_MAX));
		eld_f2 <= EL_W'(rnd_sat(eld_f1, ELBOW_MAX));
	end

	// ---------------------------------------------------------------------
	// Output: elbow-up result first, elbow-down held for the next cycle.
	// Busy keeps a new point out right after each transfer, so the hold never collides.
	// ---------------------------------------------------------------------
	logic                   done_q, pend_q, reach_q, last_q;
	logic signed [SH_W-1:0] sh_q, hsh_q;
	logic signed [EL_W-1:0] el_q, hel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			done_q <= v_f2 || pend_q;
			pend_q <= v_f2 && !unr_f2 && !sz_f2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_f2) begin
			hsh_q <= shd_f2;
			hel_q <= eld_f2;
			if (unr_f2) begin
				sh_q    <= '0;
				el_q    <= '0;
				reach_q <= 1'b0;
				last_q  <= 1'b1;
			end else begin
				sh_q    <= shu_f2;
				el_q    <= elu_f2;
				reach_q <= 1'b1;
				last_q  <= sz_f2;
			end
		end else begin
			sh_q    <= hsh_q;
			el_q    <= hel_q;
			reach_q <= 1'b1;
			last_q  <= 1'b1;
		end
	end

	assign done           = done_q;
	assign shoulder_angle = sh_q;
	assign elbow_angle    = el_q;
	assign reachable      = reach_q;
	assign last           = last_q;
endmodule

>>> sv/tlik_atan2.sv
module tlik_atan2 #(
	parameter int IW = 32
) (
	input  logic                           clk,
	input  logic signed [IW-1:0]           y,
	input  logic signed [IW-1:0]           x,
	output logic signed [tlik_pkg::Z_W-1:0] z
);
	import tlik_pkg::*;

	localparam int DN    = 6;
	localparam int UPN   = 5;
	localparam int NW    = 32;
	localparam int CW    = 34;
	localparam int STEPS = 16;
	localparam logic signed [Z_W-1:0] HALF_PI = 20'sd102944;
	localparam logic signed [63:0]    Q30     = 64'sd1073741824;

	function automatic logic signed [Z_W-1:0] atan_lut(input logic [3:0] i);
		case (i)
			4'd0:    atan_lut = 20'sd51472;
			4'd1:    atan_lut = 20'sd30386;
			4'd2:    atan_lut = 20'sd16055;
			4'd3:    atan_lut = 20'sd8150;
			4'd4:    atan_lut = 20'sd4091;
			4'd5:    atan_lut = 20'sd2047;
			4'd6:    atan_lut = 20'sd1024;
			4'd7:    atan_lut = 20'sd512;
			4'd8:    atan_lut = 20'sd256;
			4'd9:    atan_lut = 20'sd128;
			4'd10:   atan_lut = 20'sd64;
			4'd11:   atan_lut = 20'sd32;
			4'd12:   atan_lut = 20'sd16;
			4'd13:   atan_lut = 20'sd8;
			4'd14:   atan_lut = 20'sd4;
			default: atan_lut = 20'sd2;
		endcase
	endfunction

	logic                 zf_s [0:ATAN_LAT-1];
	logic signed [IW-1:0] dx_s [0:DN];
	logic signed [IW-1:0] dy_s [0:DN];
	logic signed [NW-1:0] ux_s [0:UPN];
	logic signed [NW-1:0] uy_s [0:UPN];
	logic signed [CW-1:0] cx_s [0:STEPS];
	logic signed [CW-1:0] cy_s [0:STEPS];
	logic signed [Z_W-1:0] cz_s [0:STEPS];

	always_ff @(posedge clk) begin
		dx_s[0] <= x;
		dy_s[0] <= y;
		zf_s[0] <= (x == '0) && (y == '0);
	end

	for (genvar j = 1; j < ATAN_LAT; j++) begin : g_zf
		always_ff @(posedge clk) begin
			zf_s[j] <= zf_s[j-1];
		end
	end

	// Downscale: binary search for the smallest floor shift that fits 2^30.
	for (genvar j = 1; j <= DN; j++) begin : g_dn
		localparam int SH = 1 << (DN - j);
		logic signed [IW-1:0] tx, ty;
		logic signed [63:0]   wx, wy;
		logic                 fit;
		always_comb begin
			tx  = dx_s[j-1] >>> (SH - 1);
			ty  = dy_s[j-1] >>> (SH - 1);
			wx  = 64'(tx);
			wy  = 64'(ty);
			fit = (wx > -Q30) && (wx < Q30) && (wy > -Q30) && (wy < Q30);
		end
		always_ff @(posedge clk) begin
			dx_s[j] <= fit ? dx_s[j-1] : (tx >>> 1);
			dy_s[j] <= fit ? dy_s[j-1] : (ty >>> 1);
		end
	end

	always_ff @(posedge clk) begin
		ux_s[0] <= NW'(dx_s[DN]);
		uy_s[0] <= NW'(dy_s[DN]);
	end

	// Upscale: largest left shift that keeps the larger magnitude below 2^30.
	for (genvar u = 1; u <= UPN; u++) begin : g_up
		localparam int SH = 1 << (UPN - u);
		localparam logic [NW-1:0] LIM = NW'(1) << (30 - SH);
		logic [NW-1:0] ax, ay, m;
		always_comb begin
			ax = ux_s[u-1][NW-1] ? NW'(-ux_s[u-1]) : NW'(ux_s[u-1]);
			ay = uy_s[u-1][NW-1] ? NW'(-uy_s[u-1]) : NW'(uy_s[u-1]);
			m  = (ay > ax) ? ay : ax;
		end
		always_ff @(posedge clk) begin
			ux_s[u] <= (m < LIM) ? (ux_s[u-1] <<< SH) : ux_s[u-1];
			uy_s[u] <= (m < LIM) ? (uy_s[u-1] <<< SH) : uy_s[u-1];
		end
	end

	// Fold the left half-plane onto the right one.
	always_ff @(posedge clk) begin
		if (ux_s[UPN][NW-1]) begin
			if (!uy_s[UPN][NW-1]) begin
				cx_s[0] <= CW'(uy_s[UPN]);
				cy_s[0] <= -CW'(ux_s[UPN]);
				cz_s[0] <= HALF_PI;
			end else begin
				cx_s[0] <= -CW'(uy_s[UPN]);
				cy_s[0] <= CW'(ux_s[UPN]);
				cz_s[0] <= -HALF_PI;
			end
		end else begin
			cx_s[0] <= CW'(ux_s[UPN]);
			cy_s[0] <= CW'(uy_s[UPN]);
			cz_s[0] <= '0;
		end
	end

	for (genvar i = 1; i <= STEPS; i++) begin : g_rot
		localparam logic signed [Z_W-1:0] ANG = atan_lut(4'(i - 1));
		logic signed [CW-1:0] dx, dy;
		always_comb begin
			dx = cy_s[i-1] >>> (i - 1);
			dy = cx_s[i-1] >>> (i - 1);
		end
		always_ff @(posedge clk) begin
			if (!cy_s[i-1][CW-1]) begin
				cx_s[i] <= cx_s[i-1] + dx;
				cy_s[i] <= cy_s[i-1] - dy;
				cz_s[i] <= cz_s[i-1] + ANG;
			end else begin
				cx_s[i] <= cx_s[i-1] - dx;
				cy_s[i] <= cy_s[i-1] + dy;
				cz_s[i] <= cz_s[i-1] - ANG;
			end
		end
	end

	assign z = zf_s[ATAN_LAT-1] ? '0 : cz_s[STEPS];
endmodule

>>> sv/tlik_chk.sv
`include "two_link_planar_ik_macros.svh"

module tlik_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic signed [tlik_pkg::SH_W-1:0]  shoulder_angle,
	input logic signed [tlik_pkg::EL_W-1:0]  elbow_angle,
	input logic                              reachable,
	input logic                              last
);
	import tlik_pkg::*;

	`TLIK_ASSERT(a_busy_after_take, clk, arst_n, (start && !busy) |=> busy, "busy not raised after a transfer")
	`TLIK_ASSERT(a_unreach_form, clk, arst_n, (done && !reachable) |-> (last && shoulder_angle == '0 && elbow_angle == '0), "bad out-of-reach result")
	`TLIK_ASSERT(a_second_follows, clk, arst_n, (done && !last) |=> (done && last && reachable), "second solution missing")
	`TLIK_ASSERT(a_busy_one_cycle, clk, arst_n, busy |=> !busy, "busy held for more than one cycle")
	`TLIK_ASSERT(a_elbow_range, clk, arst_n, done |-> (elbow_angle <= 16'sd25736 && elbow_angle >= -16'sd25736), "elbow angle out of range")
endmodule

bind two_link_planar_ik tlik_chk u_tlik_chk (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps

// Two-link planar inverse kinematics block under test.
// Points go in over start/busy, joint angles come back on done strobes.
// A predictor in this file works out each point's results from the
// configured link lengths. The checker compares every strobed result with
// the oldest predicted one, field by field.
module tb_top;
	import tlik_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam longint HALF_PI_Q16 = 102944;
	localparam longint SHOULDER_LIM = 51472;
	localparam longint ELBOW_LIM = 25736;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 120;
	localparam longint ATAN_STEP [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
		512, 256, 128, 64, 32, 16, 8, 4, 2};

	typedef struct {
		logic signed [SH_W-1:0] shoulder;
		logic signed [EL_W-1:0] elbow;
		logic reach;
		logic fin;
	} joint_sol_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [POS_W-1:0] target_x;
	logic signed [POS_W-1:0] target_y;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index;
	logic [LEN_W-1:0] cfg_data;
	logic done;
	logic signed [SH_W-1:0] shoulder_angle;
	logic signed [EL_W-1:0] elbow_angle;
	logic reachable;
	logic last;

	// Our own copy of the link lengths, updated on each config transfer.
	logic [LEN_W-1:0] link1_mirror;
	logic [LEN_W-1:0] link2_mirror;

	joint_sol_t pending_sols[$];
	int mismatches;
	int idle_pct;
	int stall_cycles;

	two_link_planar_ik uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.target_x(target_x),
		.target_y(target_y),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.shoulder_angle(shoulder_angle),
		.elbow_angle(elbow_angle),
		.reachable(reachable),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 60;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Vectoring CORDIC, angle in Q.16 radians; >>> on longint floors.
	function automatic longint cordic_atan2(longint y, longint x);
		longint z;
		longint t;
		longint dx;
		longint dy;
		longint unsigned m;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		// normalise the larger magnitude into [2^29, 2^30)
		forever begin
			m = abs64(x);
			if (abs64(y) > m)
				m = abs64(y);
			if (m < (64'd1 << 30))
				break;
			x = x >>> 1;
			y = y >>> 1;
		end
		while (m < (64'd1 << 29)) begin
			x *= 2;
			y *= 2;
			m *= 2;
		end
		// fold the left half-plane in by a quarter turn
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HALF_PI_Q16;
			end else begin
				x = -y;
				y = t;
				z = -HALF_PI_Q16;
			end
		end
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += ATAN_STEP[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ATAN_STEP[i];
			end
		end
		return z;
	endfunction

	// Round Q.16 to Q3.13 and saturate.
	function automatic longint round_q13(longint v, longint lim);
		longint r;
		r = (v + 4) >>> 3;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	// Append one expected result to the tail of the queue.
	function automatic void add_expected(joint_sol_t sol);
		pending_sols = {pending_sols, sol};
	endfunction

	// Work out the joint solutions for one target with the current lengths.
	task automatic predict_joints(input logic signed [POS_W-1:0] tx,
			input logic signed [POS_W-1:0] ty);
		longint x;
		longint y;
		longint l1;
		longint l2;
		longint num;
		longint den;
		longint cq;
		longint base;
		longint s1;
		longint unsigned mag;
		longint unsigned quo;
		longint unsigned rem;
		longint unsigned sn;
		joint_sol_t sol;
		x = longint'(tx);
		y = longint'(ty);
		l1 = longint'(link1_mirror);
		l2 = longint'(link2_mirror);
		sol.shoulder = '0;
		sol.elbow = '0;
		sol.reach = 1'b0;
		sol.fin = 1'b1;
		if (l1 == 0 || l2 == 0) begin
			add_expected(sol);
			return;
		end
		num = x * x + y * y - l1 * l1 - l2 * l2;
		den = 2 * l1 * l2;
		mag = abs64(num);
		// out of reach beyond one LSB of the Q1.30 cosine
		if (mag > den && mag - den > (longint'(den) >> 30)) begin
			add_expected(sol);
			return;
		end
		if (mag > den)
			mag = den;
		quo = 0;
		rem = mag;
		if (rem >= den) begin
			quo = 1;
			rem -= den;
		end
		for (int k = 0; k < 30; k++) begin
			rem <<= 1;
			quo <<= 1;
			if (rem >= den) begin
				rem -= den;
				quo |= 1;
			end
		end
		cq = num < 0 ? -longint'(quo) : longint'(quo);
		sn = int_sqrt((64'd1 << 60) - longint'(cq * cq));
		base = cordic_atan2(y, x);
		for (int k = 0; k < 2; k++) begin
			s1 = k == 0 ? longint'(sn) : -longint'(sn);
			sol.elbow = EL_W'(round_q13(cordic_atan2(s1, cq), ELBOW_LIM));
			sol.shoulder = SH_W'(round_q13(base - cordic_atan2(l2 * s1,
				(l1 << 30) + l2 * cq), SHOULDER_LIM));
			sol.reach = 1'b1;
			// zero sine: the elbow-up solution is the only one
			sol.fin = (k == 1 || sn <= 1);
			add_expected(sol);
			if (sn <= 1)
				break;
		end
	endtask

	// ---------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		joint_sol_t want;
		if (arst_n && done) begin
			if (pending_sols.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				want = pending_sols.pop_front();
				if (shoulder_angle !== want.shoulder)
					report_mismatch($sformatf("shoulder_angle %0d, want %0d",
						shoulder_angle, want.shoulder));
				if (elbow_angle !== want.elbow)
					report_mismatch($sformatf("elbow_angle %0d, want %0d",
						elbow_angle, want.elbow));
				if (reachable !== want.reach)
					report_mismatch($sformatf("reachable %0b, want %0b",
						reachable, want.reach));
				if (last !== want.fin)
					report_mismatch($sformatf("last %0b, want %0b", last, want.fin));
			end
		end
	end

	// Watchdog: end the run if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	// Send one target. start is left high on return so that back-to-back
	// points never lower and raise it in the same step.
	task automatic send_target(input logic signed [POS_W-1:0] tx,
			input logic signed [POS_W-1:0] ty);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		target_x <= tx;
		target_y <= ty;
		do
			@(posedge clk);
		while (busy);
		predict_joints(tx, ty);
	endtask

	// Hold the sender until every expected result has arrived.
	task automatic drain_results();
		start <= 1'b0;
		while (pending_sols.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Write one register, only once the pipeline has emptied.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_LINK1: link1_mirror = val;
			REG_LINK2: link2_mirror = val;
			default: ;
		endcase
	endtask

	task automatic set_links(input logic [LEN_W-1:0] a, input logic [LEN_W-1:0] b);
		write_reg(REG_LINK1, a);
		write_reg(REG_LINK2, b);
	endtask

	function automatic logic [LEN_W-1:0] rand_length();
		int sh;
		sh = $urandom_range(1, LEN_W);
		return LEN_W'($urandom_range(1, (1 << sh) - 1));
	endfunction

	// Random coordinate, mostly within the reach box of the current links.
	function automatic logic signed [POS_W-1:0] rand_coord();
		longint reach;
		reach = longint'(link1_mirror) + longint'(link2_mirror) + 2;
		if (reach > 64'sd8388607)
			reach = 64'sd8388607;
		if ($urandom_range(99) < 20)
			return POS_W'($urandom);
		return POS_W'(longint'($urandom_range(0, 32'(2 * reach))) - reach);
	endfunction

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset lengths (1.0 m each): edges of reach and the folded origin.
	task automatic test_reset_lengths();
		send_target(24'sd131072, 24'sd0);      // fully stretched, zero sine
		send_target(24'sd131073, 24'sd0);      // just past reach
		send_target(24'sd0, 24'sd0);           // folded back, zero sine
		send_target(24'sd65536, 24'sd65536);   // two solutions
		send_target(-24'sd65536, 24'sd32768);
		send_target(-24'sd92000, -24'sd10000);
		send_target(24'sd0, -24'sd131072);
		send_target(24'sd8388607, 24'sd8388607);
		send_target(-24'sd8388608, -24'sd8388608);
		send_target(24'sd8388607, -24'sd8388608);
	endtask

	// Extreme and odd lengths, including zero and the unused register slots.
	task automatic test_length_extremes();
		set_links(23'h7FFFFF, 23'h7FFFFF);
		send_target(24'sd8388607, 24'sd0);
		send_target(-24'sd8388608, 24'sd8388607);
		send_target(24'sd0, 24'sd0);
		set_links(23'd1, 23'd1);
		send_target(24'sd2, 24'sd0);
		send_target(24'sd1, 24'sd1);
		send_target(24'sd0, 24'sd0);
		send_target(24'sd3, 24'sd0);
		set_links(23'd200000, 23'd50000);
		send_target(24'sd150000, 24'sd0);      // folded, cosine -1
		send_target(-24'sd100000, 24'sd100000);
		write_reg(REG_SPARE_A, 23'h7FFFFF);
		write_reg(REG_SPARE_B, 23'h2AAAAA);
		send_target(24'sd0, 24'sd160000);
		set_links(23'd0, 23'd65536);
		send_target(24'sd65536, 24'sd0);       // zero link: unreachable
		set_links(23'd65536, 23'd0);
		send_target(24'sd65536, 24'sd0);
	endtask

	// Random phases with random lengths; the first runs with no idling.
	task automatic test_random_targets();
		for (int phase = 0; phase < 7; phase++) begin
			set_links(rand_length(), rand_length());
			idle_pct = phase == 0 ? 0 : 23;
			for (int n = 0; n < 200; n++) begin
				send_target(rand_coord(), rand_coord());
				// pause once, midway through the fourth phase, until everything has come back
				if (n == 100 && phase == 3)
					drain_results();
			end
		end
		set_links(LEN_RESET, LEN_RESET);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		target_x = '0;
		target_y = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		link1_mirror = LEN_RESET;
		link2_mirror = LEN_RESET;
		idle_pct = 23;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_lengths();
		test_length_extremes();
		test_random_targets();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

>>> files.f
+incdir+sv
sv/tlik_pkg.sv
sv/tlik_atan2.sv
sv/two_link_planar_ik.sv
sv/tlik_chk.sv
test/tb_top.sv
